// ----- rtl/chs_pkg.sv -----
// Package for the chained hash set unit: field widths, op and status codes.
// No dependencies.
package chs_pkg;
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 31;
    localparam int CFG_W    = 7;
    localparam int STATUS_W = 2;
    localparam int BKT_W    = 6;
    localparam int TOTAL_W  = 9;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
endpackage

// ----- rtl/chs_if.sv -----
// Request and result channel interfaces of the chained hash set unit.
// Depends on chs_pkg.
interface chs_req_if;
    logic                         valid;
    logic                         ready;
    logic [chs_pkg::OP_W-1:0]     op;
    logic [chs_pkg::VALUE_W-1:0]  value;
    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface chs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [chs_pkg::STATUS_W-1:0]  status;
    logic [chs_pkg::BKT_W-1:0]     bucket;
    logic [chs_pkg::TOTAL_W-1:0]   entry_total;
    logic                          is_empty;
    modport source (output valid, output status, output bucket, output entry_total,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input bucket, input entry_total,
                    input is_empty, output ready);
endinterface

// ----- rtl/chained_hash_set_unit.sv -----
// Chained hash set unit: bucket head memory, node value and link memories, FSM.
// Depends on chs_pkg and chs_if.
//
// After reset the head memory is cleared in one pass over all buckets, during which no
// request is taken. Requests are taken one at a time, only in idle. Each request computes
// value modulo the configured modulus in a bit-serial divider (the bucket head is fetched
// in its last step), reads the head and either inserts (S_INS) or walks the chain through
// the node memories, a S_WALK and S_CMP per node, plus S_REM1 and S_REM2 to unlink on
// a remove, then loads the result register in S_OUT; an unused op goes from the divider
// straight to S_OUT. The next request can be taken in the cycle after the result is
// loaded; a previous result not yet taken stalls the load.
module chained_hash_set_unit #(
    parameter int BUCKETS = 64,
    parameter int NODES   = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    chs_req_if.sink                   i_req,
    chs_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [chs_pkg::CFG_W-1:0] i_cfg_data
);
    import chs_pkg::*;

    localparam int NW = $clog2(NODES + 1);
    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int MW = $clog2(BUCKETS + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);
    localparam logic [BW-1:0] LAST_BKT = BW'(BUCKETS - 1);
    localparam logic [4:0] DIV_LAST = 5'(VALUE_W - 1);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_HREAD = 10'b0000001000,
        S_INS   = 10'b0000010000,
        S_WALK  = 10'b0000100000,
        S_CMP   = 10'b0001000000,
        S_REM1  = 10'b0010000000,
        S_REM2  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    logic [NW-1:0]      heads_mem [BUCKETS];
    logic [VALUE_W-1:0] val_mem   [NODES];
    logic [NW-1:0]      link_mem  [NODES];

    t_state             r_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [BW-1:0]      r_clr;
    logic [OP_W-1:0]    r_op;
    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] r_dvd;
    logic [MW-1:0]      r_mod;
    logic [MW-1:0]      r_rem;
    logic [4:0]         r_cnt;
    logic [BW-1:0]      r_h;
    logic [NW-1:0]      r_cur;
    logic [NW-1:0]      r_prev;
    logic [NW-1:0]      r_free;
    logic [NW-1:0]      r_fresh;
    logic [NW-1:0]      r_count;
    logic [STATUS_W-1:0] r_status;
    logic [NW-1:0]      r_head_q;
    logic [VALUE_W-1:0] r_val_q;
    logic [NW-1:0]      r_link_q;
    logic               r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [BKT_W-1:0]   r_out_bucket;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_empty;

    logic [MW-1:0]  n_mod;
    logic [MW:0]    n_trial;
    logic [MW-1:0]  n_rem;
    logic           hd_we;
    logic [BW-1:0]  hd_addr;
    logic [NW-1:0]  hd_wdata;
    logic           vl_we;
    logic [AW-1:0]  vl_waddr;
    logic           lk_we;
    logic [AW-1:0]  lk_waddr;
    logic [NW-1:0]  lk_wdata;
    logic [AW-1:0]  nd_raddr;
    logic [NW-1:0]  n_node;
    logic           req_fire;

    assign req_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        if (r_cfg == '0) begin
            n_mod = MW'(1);
        end else if (32'(r_cfg) > BUCKETS) begin
            n_mod = MW'(BUCKETS);
        end else begin
            n_mod = MW'(r_cfg);
        end
    end

    always_comb begin
        n_trial = {r_rem, r_dvd[VALUE_W-1]};
        if (n_trial >= {1'b0, r_mod}) begin
            n_rem = MW'(n_trial - {1'b0, r_mod});
        end else begin
            n_rem = MW'(n_trial);
        end
    end

    always_comb begin
        if (r_free != NIL) begin
            n_node = r_free;
        end else begin
            n_node = r_fresh;
        end
    end

    // memory port controls
    always_comb begin
        hd_we    = 1'b0;
        hd_addr  = r_h;
        hd_wdata = r_link_q;
        vl_we    = 1'b0;
        vl_waddr = n_node[AW-1:0];
        lk_we    = 1'b0;
        lk_waddr = n_node[AW-1:0];
        lk_wdata = r_head_q;
        nd_raddr = r_cur[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                hd_we    = 1'b1;
                hd_addr  = r_clr;
                hd_wdata = NIL;
            end
            S_DIV: begin
                hd_addr = BW'(n_rem);
            end
            S_HREAD: begin
                nd_raddr = r_free[AW-1:0];
            end
            S_INS: begin
                if (n_node != NIL) begin
                    hd_we    = 1'b1;
                    hd_wdata = n_node;
                    vl_we    = 1'b1;
                    lk_we    = 1'b1;
                end
            end
            S_REM1: begin
                if (r_prev != NIL) begin
                    lk_we    = 1'b1;
                    lk_waddr = r_prev[AW-1:0];
                    lk_wdata = r_link_q;
                end else begin
                    hd_we = 1'b1;
                end
            end
            S_REM2: begin
                lk_we    = 1'b1;
                lk_waddr = r_cur[AW-1:0];
                lk_wdata = r_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hd_we) begin
            heads_mem[hd_addr] <= hd_wdata;
        end
        r_head_q <= heads_mem[hd_addr];
        if (vl_we) begin
            val_mem[vl_waddr] <= r_val;
        end
        if (lk_we) begin
            link_mem[lk_waddr] <= lk_wdata;
        end
        r_val_q  <= val_mem[nd_raddr];
        r_link_q <= link_mem[nd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cfg       <= CFG_RESET;
            r_clr       <= '0;
            r_free      <= NIL;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (o_rsp.valid && o_rsp.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + BW'(1);
                    if (r_clr == LAST_BKT) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        r_op     <= i_req.op;
                        r_val    <= i_req.value;
                        r_dvd    <= i_req.value;
                        r_mod    <= n_mod;
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_status <= ST_ABSENT;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[VALUE_W-2:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_h <= BW'(n_rem);
                        if (r_op inside {OP_INSERT, OP_SEARCH, OP_REMOVE}) begin
                            r_state <= S_HREAD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_HREAD: begin
                    if (r_op == OP_INSERT) begin
                        r_state <= S_INS;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_INS: begin
                    if (r_free != NIL) begin
                        r_free   <= r_link_q;
                        r_count  <= r_count + NW'(1);
                        r_status <= ST_OK;
                    end else if (r_fresh != NIL) begin
                        r_fresh  <= r_fresh + NW'(1);
                        r_count  <= r_count + NW'(1);
                        r_status <= ST_OK;
                    end else begin
                        r_status <= ST_FULL;
                    end
                    r_state <= S_OUT;
                end
                S_WALK: begin
                    if (r_cur == NIL) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_val_q == r_val) begin
                        r_status <= ST_OK;
                        if (r_op == OP_REMOVE) begin
                            r_state <= S_REM1;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_prev  <= r_cur;
                        r_cur   <= r_link_q;
                        r_state <= S_WALK;
                    end
                end
                S_REM1: begin
                    r_state <= S_REM2;
                end
                S_REM2: begin
                    r_free <= r_cur;
                    if (r_count != '0) begin
                        r_count <= r_count - NW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_bucket <= (r_status == ST_OK) ? BKT_W'(r_h) : '0;
                        r_out_total  <= TOTAL_W'(r_count);
                        r_out_empty  <= (r_count == '0);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (r_state == S_HREAD) begin
                r_cur  <= r_head_q;
                r_prev <= NIL;
            end
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.bucket      = r_out_bucket;
    assign o_rsp.entry_total = r_out_total;
    assign o_rsp.is_empty    = r_out_empty;
endmodule

// ----- rtl/chs_chk.sv -----
// Port-level checker for the chained hash set unit, bound to the top level.
// Depends on chs_pkg.
module chs_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_rsp_valid,
    input logic                           i_rsp_ready,
    input logic [chs_pkg::STATUS_W-1:0]   i_status,
    input logic [chs_pkg::BKT_W-1:0]      i_bucket,
    input logic [chs_pkg::TOTAL_W-1:0]    i_total,
    input logic                           i_empty
);
    import chs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_empty == (i_total == '0)))
        else $error("is_empty disagrees with entry_total");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_status == ST_OK || i_status == ST_FULL || i_status == ST_ABSENT))
        else $error("bad status code");

    a_bucket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_OK |-> i_bucket == '0)
        else $error("bucket set on failed request");
endmodule

bind chained_hash_set_unit chs_chk u_chs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_bucket    (o_rsp.bucket),
    .i_total     (o_rsp.entry_total),
    .i_empty     (o_rsp.is_empty)
);

// ----- bench/tb_chained_hash_set_unit.sv -----
// Testbench for chained_hash_set_unit: directed and random insert/search/remove requests,
// checked against a behavioral hash-set predictor held in a small scoreboard class.
// Depends on chs_pkg, chs_if and the RTL of chained_hash_set_unit.
module tb_chained_hash_set_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import chs_pkg::*;

    localparam int NB = 64;
    localparam int NN = 256;
    localparam int NIL = NN;
    localparam longint LIMIT = 4000000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BKT_W-1:0]    bucket;
        logic [TOTAL_W-1:0]  entry_total;
        logic                is_empty;
    } rsp_t;

    class hash_set_board;
        int heads[NB];
        logic [VALUE_W-1:0] vals[NN];
        int links[NN];
        int free_head, fresh, count;
        int modulus_reg;
        rsp_t pending[$];
        int errors;

        function new();
            foreach (heads[i]) heads[i] = NIL;
            free_head = NIL;
            fresh = 0;
            count = 0;
            modulus_reg = CFG_RESET;
            errors = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v);
            int m, h, cur, prev, n;
            rsp_t r;
            m = modulus_reg < 1 ? 1 : (modulus_reg > NB ? NB : modulus_reg);
            h = v % m;
            r = '0;
            r.status = ST_ABSENT;
            if (op == OP_INSERT) begin
                n = NIL;
                if (free_head < NIL) begin
                    n = free_head;
                    free_head = links[n];
                end else if (fresh < NIL) begin
                    n = fresh;
                    fresh++;
                end
                if (n < NIL) begin
                    vals[n] = v;
                    links[n] = heads[h];
                    heads[h] = n;
                    count++;
                    r.status = ST_OK;
                    r.bucket = BKT_W'(h);
                end else begin
                    r.status = ST_FULL;
                end
            end else if (op == OP_SEARCH || op == OP_REMOVE) begin
                cur = heads[h];
                prev = NIL;
                while (cur < NIL) begin
                    if (vals[cur] == v) begin
                        r.status = ST_OK;
                        r.bucket = BKT_W'(h);
                        if (op == OP_REMOVE) begin
                            if (prev < NIL) links[prev] = links[cur];
                            else heads[h] = links[cur];
                            links[cur] = free_head;
                            free_head = cur;
                            if (count > 0) count--;
                        end
                        break;
                    end
                    prev = cur;
                    cur = links[cur];
                end
            end
            r.entry_total = TOTAL_W'(count);
            r.is_empty = (count == 0);
            pending.push_back(r);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p actual %p", exp, got);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    chs_req_if req_if();
    chs_rsp_if rsp_if();

    hash_set_board board = new();
    longint cycles = 0;
    bit sink_stall_on = 1;
    int long_hold = 0;
    logic [VALUE_W-1:0] keys[$];

    chained_hash_set_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        req_if.valid = 0;
        req_if.op = '0;
        req_if.value = '0;
        rsp_if.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_chained_hash_set_unit NOT OK");
            $finish;
        end
    end

    // result side: random stall bursts, long hold on request
    initial begin : sink
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold > 0) begin
                rsp_if.ready <= 0;
                repeat (long_hold) @(posedge i_clk);
                long_hold = 0;
            end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 17);
                rsp_if.ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1;
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                board.check_result({rsp_if.status, rsp_if.bucket, rsp_if.entry_total,
                                    rsp_if.is_empty});
        end
    end

    bit src_stall_on = 1;

    task automatic send_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] v);
        int gap;
        if (src_stall_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            req_if.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1;
        req_if.op <= op;
        req_if.value <= v;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        board.note_request(op, v);
        if (op == OP_INSERT) keys.push_back(v);
    endtask

    task automatic drain();
        req_if.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [CFG_W-1:0] m);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 0;
        board.modulus_reg = m;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 3) == 0 ? '1 : '0;
            1: return VALUE_W'($urandom());
            2: return VALUE_W'($urandom_range(0, 300));
            default: return keys.size() ? keys[$urandom_range(0, keys.size() - 1)]
                                        : VALUE_W'($urandom_range(0, 100));
        endcase
    endfunction

    task automatic random_phase(int n);
        int k;
        logic [OP_W-1:0] op;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: op = OP_INSERT;
                4, 5, 6: op = OP_SEARCH;
                7, 8: op = OP_REMOVE;
                default: op = OP_UNUSED;
            endcase
            send_request(op, pick_value());
        end
    endtask

    initial begin : main
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty table, extremes, duplicates, unused op
        send_request(OP_SEARCH, 31'd5);
        send_request(OP_REMOVE, 31'd5);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, 31'd64);
        send_request(OP_INSERT, 31'd64);
        send_request(OP_SEARCH, '1);
        send_request(OP_SEARCH, 31'd128);
        send_request(OP_REMOVE, 31'd64);
        send_request(OP_SEARCH, 31'd64);
        send_request(OP_REMOVE, '0);
        send_request(OP_UNUSED, 31'h2aaa_aaaa);
        send_request(OP_INSERT, 31'h5555_5555);
        send_request(OP_REMOVE, 31'd64);
        send_request(OP_REMOVE, '1);

        // modulus 0 acts as 1, above range acts as 64
        write_modulus(7'd0);
        send_request(OP_INSERT, 31'd77);
        send_request(OP_SEARCH, 31'd77);
        write_modulus(7'd127);
        send_request(OP_SEARCH, 31'h5555_5555);
        send_request(OP_INSERT, 31'd200);
        write_modulus(7'd1);
        random_phase(200);

        // fill the pool to force refusals, with a long result hold
        write_modulus(7'd3);
        long_hold = 400;
        for (k = 0; k < 270; k++) send_request(OP_INSERT, VALUE_W'($urandom_range(0, 2000)));
        random_phase(150);
        drain();
        for (k = 0; k < 120; k++)
            send_request(OP_REMOVE, keys[$urandom_range(0, keys.size() - 1)]);

        write_modulus(7'd64);
        random_phase(300);
        write_modulus(7'd17);
        random_phase(300);
        write_modulus(7'd65);
        random_phase(200);
        write_modulus(7'd40);
        src_stall_on = 0;
        sink_stall_on = 0;
        random_phase(250);

        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_chained_hash_set_unit OK");
        else
            $display("tb_chained_hash_set_unit NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/chs_pkg.sv
rtl/chs_if.sv
rtl/chained_hash_set_unit.sv
rtl/chs_chk.sv
bench/tb_chained_hash_set_unit.sv
